[design/sct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sct_pkg;

  localparam int RADIUS_BITS = 15;

  typedef enum logic [1:0] {
    OP_SEG    = 2'd0,
    OP_BOX    = 2'd1,
    OP_CIRCLE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

endpackage
`default_nettype wire

[design/sct_wide_cmp.sv]
`timescale 1ns / 1ps
`default_nettype none
// Two-stage check of cross^2 <= r^2 * len2, built from half-width partial products.
module sct_wide_cmp #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic signed [2*COORD_BITS+4:0] cross_i,
  input  wire logic signed [2*COORD_BITS+4:0] len2_i,
  input  wire logic [2*sct_pkg::RADIUS_BITS-1:0] r2_i,
  output logic                               near_o
);

  localparam int HW  = COORD_BITS + 2;
  localparam int SW  = 2 * COORD_BITS + 5;
  localparam int R2W = 2 * sct_pkg::RADIUS_BITS;
  localparam int QW  = (4 * HW > R2W + 2 * HW + 1) ? 4 * HW : R2W + 2 * HW + 1;

  logic [2*HW-1:0] cmag;
  logic [2*HW-1:0] lmag;
  logic [HW-1:0]   ch, cl, lh, ll;

  logic [2*HW-1:0]   hh_r, hl_r, ll_r;
  logic [2*HW-1:0]   hh_nxt, hl_nxt, ll_nxt;
  logic [R2W+HW-1:0] rh_r, rl_r, rh_nxt, rl_nxt;
  logic [QW-1:0]     csq_r, rsq_r, csq_nxt, rsq_nxt;

  always_comb begin
    if (cross_i < 0) begin
      cmag = (2*HW)'(-cross_i);
    end else begin
      cmag = (2*HW)'(cross_i);
    end
    lmag = len2_i[SW-2:0];
    ch = cmag[2*HW-1:HW];
    cl = cmag[HW-1:0];
    lh = lmag[2*HW-1:HW];
    ll = lmag[HW-1:0];
    hh_nxt = (2*HW)'(ch) * (2*HW)'(ch);
    hl_nxt = (2*HW)'(ch) * (2*HW)'(cl);
    ll_nxt = (2*HW)'(cl) * (2*HW)'(cl);
    rh_nxt = (R2W+HW)'(r2_i) * (R2W+HW)'(lh);
    rl_nxt = (R2W+HW)'(r2_i) * (R2W+HW)'(ll);
    csq_nxt = (QW'(hh_r) << (2*HW)) + (QW'(hl_r) << (HW+1)) + QW'(ll_r);
    rsq_nxt = (QW'(rh_r) << HW) + QW'(rl_r);
  end

  always_ff @(posedge clk) begin
    hh_r  <= hh_nxt;
    hl_r  <= hl_nxt;
    ll_r  <= ll_nxt;
    rh_r  <= rh_nxt;
    rl_r  <= rl_nxt;
    csq_r <= csq_nxt;
    rsq_r <= rsq_nxt;
  end

  assign near_o = (csq_r <= rsq_r);

endmodule
`default_nettype wire

[design/segment_collision_tests_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// A request taken at one clock edge has its result on out_hit with out_valid after the
// stages below. Throughput: one request per cycle, every cycle; busy stays low.
// Six register stages: differences, products, sums, decisions and partial products,
// wide products, and the output register.
// Reset (synchronous, active low) clears the valid bits; the receiver cannot stall.
module segment_collision_tests_top #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_opcode,
  input  wire logic signed [COORD_BITS-1:0]   in_seg_x,
  input  wire logic signed [COORD_BITS-1:0]   in_seg_y,
  input  wire logic signed [COORD_BITS-1:0]   in_seg_dx,
  input  wire logic signed [COORD_BITS-1:0]   in_seg_dy,
  input  wire logic signed [COORD_BITS-1:0]   in_other_x,
  input  wire logic signed [COORD_BITS-1:0]   in_other_y,
  input  wire logic signed [COORD_BITS-1:0]   in_other_u,
  input  wire logic signed [COORD_BITS-1:0]   in_other_v,
  input  wire logic [sct_pkg::RADIUS_BITS-1:0] in_radius,
  output logic                                out_valid,
  output logic                                out_hit
);

  localparam int C   = COORD_BITS;
  localparam int C1  = C + 1;
  localparam int C2  = C + 2;
  localparam int PW  = 2 * C + 4;
  localparam int SW  = 2 * C + 5;
  localparam int RB  = sct_pkg::RADIUS_BITS;
  localparam int R2W = 2 * RB;

  // Product slots.
  localparam int P_DXOV = 0,  P_DYOU = 1,  P_AOV  = 2,  P_COU  = 3;
  localparam int P_ADY  = 4,  P_CDX  = 5,  P_DYW  = 6,  P_CW   = 7;
  localparam int P_EW   = 8,  P_DXH  = 9,  P_AH   = 10, P_BH   = 11;
  localparam int P_BDY  = 12, P_EDX  = 13, P_ADX  = 14, P_CDY  = 15;
  localparam int P_VXDX = 16, P_VYDY = 17, P_DXDX = 18, P_DYDY = 19;
  localparam int P_AA   = 20, P_CC   = 21, P_VXVX = 22, P_VYVY = 23;
  localparam int NP     = 24;

  // Sum slots.
  localparam int S_DEN0 = 0,  S_N10  = 1,  S_N20  = 2,  S_DENA = 3;
  localparam int S_N1E1 = 4,  S_N1E4 = 5,  S_DENB = 6,  S_N1E2 = 7;
  localparam int S_N1E3 = 8,  S_N2E3 = 9,  S_N2E4 = 10, S_CROSS = 11;
  localparam int S_DOT1 = 12, S_DOT2 = 13, S_LEN2 = 14, S_D2W  = 15;
  localparam int S_D2V  = 16;
  localparam int NS     = 17;

  typedef struct packed {
    logic [1:0] op;
    logic       seg_hit;
    logic       box_hit;
    logic       len_zero;
    logic       between;
    logic       in_w;
    logic       in_v;
  } flags_t;

  function automatic logic seg_test(input logic signed [SW-1:0] den,
                                    input logic signed [SW-1:0] n1,
                                    input logic signed [SW-1:0] n2);
    logic ok;
    if (den > 0) begin
      ok = (n1 >= 0) && (n1 <= den) && (n2 >= 0) && (n2 <= den);
    end else begin
      ok = (n1 <= 0) && (n1 >= den) && (n2 <= 0) && (n2 >= den);
    end
    return (den != 0) && ok;
  endfunction

  // Stage 1: differences.
  logic                   v1_r;
  logic [1:0]             op1_r;
  logic signed [C-1:0]    dx1_r, dy1_r, ou1_r, ov1_r;
  logic signed [C1-1:0]   a1_r, b1_r, c1_r, e1_r, w1_r, h1_r;
  logic signed [C2-1:0]   vx1_r, vy1_r;
  logic [RB-1:0]          r1_r;

  // Stage 2: products.
  logic                   v2_r;
  logic [1:0]             op2_r;
  logic signed [C2-1:0]   mul_a [NP];
  logic signed [C2-1:0]   mul_b [NP];
  logic signed [PW-1:0]   prod_r [NP];
  logic signed [PW-1:0]   prod_nxt [NP];
  logic [R2W-1:0]         r2_2_r, r2_nxt;

  // Stage 3: sums.
  logic                   v3_r;
  logic [1:0]             op3_r;
  logic signed [SW-1:0]   sum_r [NS];
  logic signed [SW-1:0]   sum_nxt [NS];
  logic [R2W-1:0]         r2_3_r;

  // Stages 4 and 5: decisions, wide compare in flight.
  logic                   v4_r, v5_r;
  flags_t                 fl4_r, fl5_r, fl_nxt;
  logic                   near;
  logic                   circ_hit;
  logic                   hit_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      out_valid <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    op1_r <= in_opcode;
    dx1_r <= in_seg_dx;
    dy1_r <= in_seg_dy;
    ou1_r <= in_other_u;
    ov1_r <= in_other_v;
    a1_r  <= C1'(in_other_x) - C1'(in_seg_x);
    c1_r  <= C1'(in_other_y) - C1'(in_seg_y);
    b1_r  <= C1'(in_other_u) - C1'(in_seg_x);
    e1_r  <= C1'(in_other_v) - C1'(in_seg_y);
    w1_r  <= C1'(in_other_u) - C1'(in_other_x);
    h1_r  <= C1'(in_other_v) - C1'(in_other_y);
    vx1_r <= C2'(in_other_x) - C2'(in_seg_x) - C2'(in_seg_dx);
    vy1_r <= C2'(in_other_y) - C2'(in_seg_y) - C2'(in_seg_dy);
    r1_r  <= in_radius;
  end

  always_comb begin
    mul_a[P_DXOV] = C2'(dx1_r); mul_b[P_DXOV] = C2'(ov1_r);
    mul_a[P_DYOU] = C2'(dy1_r); mul_b[P_DYOU] = C2'(ou1_r);
    mul_a[P_AOV]  = C2'(a1_r);  mul_b[P_AOV]  = C2'(ov1_r);
    mul_a[P_COU]  = C2'(c1_r);  mul_b[P_COU]  = C2'(ou1_r);
    mul_a[P_ADY]  = C2'(a1_r);  mul_b[P_ADY]  = C2'(dy1_r);
    mul_a[P_CDX]  = C2'(c1_r);  mul_b[P_CDX]  = C2'(dx1_r);
    mul_a[P_DYW]  = C2'(dy1_r); mul_b[P_DYW]  = C2'(w1_r);
    mul_a[P_CW]   = C2'(c1_r);  mul_b[P_CW]   = C2'(w1_r);
    mul_a[P_EW]   = C2'(e1_r);  mul_b[P_EW]   = C2'(w1_r);
    mul_a[P_DXH]  = C2'(dx1_r); mul_b[P_DXH]  = C2'(h1_r);
    mul_a[P_AH]   = C2'(a1_r);  mul_b[P_AH]   = C2'(h1_r);
    mul_a[P_BH]   = C2'(b1_r);  mul_b[P_BH]   = C2'(h1_r);
    mul_a[P_BDY]  = C2'(b1_r);  mul_b[P_BDY]  = C2'(dy1_r);
    mul_a[P_EDX]  = C2'(e1_r);  mul_b[P_EDX]  = C2'(dx1_r);
    mul_a[P_ADX]  = C2'(a1_r);  mul_b[P_ADX]  = C2'(dx1_r);
    mul_a[P_CDY]  = C2'(c1_r);  mul_b[P_CDY]  = C2'(dy1_r);
    mul_a[P_VXDX] = vx1_r;      mul_b[P_VXDX] = C2'(dx1_r);
    mul_a[P_VYDY] = vy1_r;      mul_b[P_VYDY] = C2'(dy1_r);
    mul_a[P_DXDX] = C2'(dx1_r); mul_b[P_DXDX] = C2'(dx1_r);
    mul_a[P_DYDY] = C2'(dy1_r); mul_b[P_DYDY] = C2'(dy1_r);
    mul_a[P_AA]   = C2'(a1_r);  mul_b[P_AA]   = C2'(a1_r);
    mul_a[P_CC]   = C2'(c1_r);  mul_b[P_CC]   = C2'(c1_r);
    mul_a[P_VXVX] = vx1_r;      mul_b[P_VXVX] = vx1_r;
    mul_a[P_VYVY] = vy1_r;      mul_b[P_VYVY] = vy1_r;
    for (int i = 0; i < NP; i++) begin
      prod_nxt[i] = PW'(mul_a[i]) * PW'(mul_b[i]);
    end
    r2_nxt = R2W'(r1_r) * R2W'(r1_r);
  end

  always_ff @(posedge clk) begin
    op2_r  <= op1_r;
    r2_2_r <= r2_nxt;
    for (int i = 0; i < NP; i++) begin
      prod_r[i] <= prod_nxt[i];
    end
  end

  // Edges along x have direction (w, 0); edges along y have direction (0, h).
  always_comb begin
    sum_nxt[S_DEN0]  = SW'(prod_r[P_DXOV]) - SW'(prod_r[P_DYOU]);
    sum_nxt[S_N10]   = SW'(prod_r[P_AOV])  - SW'(prod_r[P_COU]);
    sum_nxt[S_N20]   = SW'(prod_r[P_ADY])  - SW'(prod_r[P_CDX]);
    sum_nxt[S_DENA]  = -SW'(prod_r[P_DYW]);
    sum_nxt[S_N1E1]  = -SW'(prod_r[P_CW]);
    sum_nxt[S_N1E4]  = -SW'(prod_r[P_EW]);
    sum_nxt[S_DENB]  = SW'(prod_r[P_DXH]);
    sum_nxt[S_N1E2]  = SW'(prod_r[P_AH]);
    sum_nxt[S_N1E3]  = SW'(prod_r[P_BH]);
    sum_nxt[S_N2E3]  = SW'(prod_r[P_BDY])  - SW'(prod_r[P_CDX]);
    sum_nxt[S_N2E4]  = SW'(prod_r[P_ADY])  - SW'(prod_r[P_EDX]);
    sum_nxt[S_CROSS] = SW'(prod_r[P_CDX])  - SW'(prod_r[P_ADY]);
    sum_nxt[S_DOT1]  = SW'(prod_r[P_ADX])  + SW'(prod_r[P_CDY]);
    sum_nxt[S_DOT2]  = SW'(prod_r[P_VXDX]) + SW'(prod_r[P_VYDY]);
    sum_nxt[S_LEN2]  = SW'(prod_r[P_DXDX]) + SW'(prod_r[P_DYDY]);
    sum_nxt[S_D2W]   = SW'(prod_r[P_AA])   + SW'(prod_r[P_CC]);
    sum_nxt[S_D2V]   = SW'(prod_r[P_VXVX]) + SW'(prod_r[P_VYVY]);
  end

  always_ff @(posedge clk) begin
    op3_r  <= op2_r;
    r2_3_r <= r2_2_r;
    for (int i = 0; i < NS; i++) begin
      sum_r[i] <= sum_nxt[i];
    end
  end

  always_comb begin
    fl_nxt.op       = op3_r;
    fl_nxt.seg_hit  = seg_test(sum_r[S_DEN0], sum_r[S_N10], sum_r[S_N20]);
    fl_nxt.box_hit  = seg_test(sum_r[S_DENA], sum_r[S_N1E1], sum_r[S_N20])
                   || seg_test(sum_r[S_DENB], sum_r[S_N1E2], sum_r[S_N20])
                   || seg_test(sum_r[S_DENB], sum_r[S_N1E3], sum_r[S_N2E3])
                   || seg_test(sum_r[S_DENA], sum_r[S_N1E4], sum_r[S_N2E4]);
    fl_nxt.len_zero = (sum_r[S_LEN2] == 0);
    fl_nxt.between  = (sum_r[S_DOT1] == 0) || (sum_r[S_DOT2] == 0)
                   || ((sum_r[S_DOT1] < 0) != (sum_r[S_DOT2] < 0));
    fl_nxt.in_w     = (sum_r[S_D2W] < $signed({1'b0, SW'(r2_3_r)}));
    fl_nxt.in_v     = (sum_r[S_D2V] < $signed({1'b0, SW'(r2_3_r)}));
  end

  always_ff @(posedge clk) begin
    fl4_r <= fl_nxt;
    fl5_r <= fl4_r;
  end

  sct_wide_cmp #(
    .COORD_BITS(COORD_BITS)
  ) u_wide_cmp (
    .clk     (clk),
    .cross_i (sum_r[S_CROSS]),
    .len2_i  (sum_r[S_LEN2]),
    .r2_i    (r2_3_r),
    .near_o  (near)
  );

  always_comb begin
    if (fl5_r.len_zero) begin
      circ_hit = fl5_r.in_w;
    end else begin
      circ_hit = near && (fl5_r.between || fl5_r.in_w || fl5_r.in_v);
    end
    unique case (sct_pkg::op_t'(fl5_r.op))
      sct_pkg::OP_SEG:    hit_nxt = fl5_r.seg_hit;
      sct_pkg::OP_BOX:    hit_nxt = fl5_r.box_hit;
      sct_pkg::OP_CIRCLE: hit_nxt = circ_hit;
      default:            hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    out_hit <= hit_nxt;
  end

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##6 out_valid)
    else $error("accepted request did not reach the output after six cycles");

  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 6))
    else $error("result without a matching request");

  a_unused_op : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_opcode, 6) == sct_pkg::OP_NONE) |-> !out_hit)
    else $error("unused opcode reported a hit");

  a_point_seg : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_opcode == sct_pkg::OP_SEG && in_seg_dx == 0
                        && in_seg_dy == 0, 6)) |-> !out_hit)
    else $error("zero-length segment reported a segment hit");

endmodule
`default_nettype wire

[sim/segment_collision_tests_top_test.sv]
`timescale 1ns / 1ps
module segment_collision_tests_top_test;

  localparam int RB = sct_pkg::RADIUS_BITS;

  typedef struct {
    sct_pkg::op_t opcode;
    logic signed [15:0] seg_x, seg_y, seg_dx, seg_dy;
    logic signed [15:0] other_x, other_y, other_u, other_v;
    logic [RB-1:0] radius;
  } query_t;

  class hit_scoreboard;
    bit pending_hits[$];
    int errors;
    int queries;
    int hits;
    int per_op[4];

    function bit crosses(longint px, longint py, longint dx, longint dy,
                         longint qx, longint qy, longint ex, longint ey);
      longint vx, vy, den, n1, n2;
      vx = qx - px;
      vy = qy - py;
      den = dx * ey - dy * ex;
      n1 = vx * ey - vy * ex;
      n2 = vx * dy - vy * dx;
      if (den == 0) return 1'b0;
      if (den < 0) begin
        den = -den;
        n1 = -n1;
        n2 = -n2;
      end
      return n1 >= 0 && n1 <= den && n2 >= 0 && n2 <= den;
    endfunction

    function bit point_inside(longint wx, longint wy, longint r);
      return wx * wx + wy * wy < r * r;
    endfunction

    function bit touches_circle(longint px, longint py, longint dx, longint dy,
                                longint cx, longint cy, longint r);
      longint wx, wy, vx, vy, len2, cr, dot1, dot2;
      bit [127:0] cr_sq, reach_sq;
      wx = cx - px;
      wy = cy - py;
      vx = wx - dx;
      vy = wy - dy;
      len2 = dx * dx + dy * dy;
      if (len2 == 0) return point_inside(wx, wy, r);
      cr = dx * wy - dy * wx;
      if (cr < 0) cr = -cr;
      cr_sq = 128'(cr) * 128'(cr);
      reach_sq = 128'(r * r) * 128'(len2);
      if (cr_sq > reach_sq) return 1'b0;
      dot1 = wx * dx + wy * dy;
      dot2 = vx * dx + vy * dy;
      if (dot1 == 0 || dot2 == 0 || ((dot1 < 0) != (dot2 < 0))) return 1'b1;
      return point_inside(wx, wy, r) || point_inside(vx, vy, r);
    endfunction

    function void note_query(query_t q);
      bit h;
      longint w, ht;
      h = 1'b0;
      w = longint'(q.other_u) - longint'(q.other_x);
      ht = longint'(q.other_v) - longint'(q.other_y);
      case (q.opcode)
        sct_pkg::OP_SEG: h = crosses(q.seg_x, q.seg_y, q.seg_dx, q.seg_dy,
                                     q.other_x, q.other_y, q.other_u, q.other_v);
        sct_pkg::OP_BOX: h = crosses(q.seg_x, q.seg_y, q.seg_dx, q.seg_dy,
                                     q.other_x, q.other_y, w, 0)
                          || crosses(q.seg_x, q.seg_y, q.seg_dx, q.seg_dy,
                                     q.other_x, q.other_y, 0, ht)
                          || crosses(q.seg_x, q.seg_y, q.seg_dx, q.seg_dy,
                                     q.other_u, q.other_y, 0, ht)
                          || crosses(q.seg_x, q.seg_y, q.seg_dx, q.seg_dy,
                                     q.other_x, q.other_v, w, 0);
        sct_pkg::OP_CIRCLE: h = touches_circle(q.seg_x, q.seg_y, q.seg_dx, q.seg_dy,
                                               q.other_x, q.other_y,
                                               longint'(q.radius));
        default: h = 1'b0;
      endcase
      pending_hits.push_back(h);
      queries++;
      per_op[q.opcode]++;
      if (h) hits++;
    endfunction

    function void check_hit(bit actual);
      bit want;
      if (pending_hits.size() == 0) begin
        $error("unexpected result: hit=%0d with no request outstanding", actual);
        errors++;
        return;
      end
      want = pending_hits.pop_front();
      if (want !== actual) begin
        $error("mismatch on hit: expected %0d, actual %0d", want, actual);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_opcode;
  logic signed [15:0] in_seg_x, in_seg_y, in_seg_dx, in_seg_dy;
  logic signed [15:0] in_other_x, in_other_y, in_other_u, in_other_v;
  logic [RB-1:0] in_radius;
  logic out_valid;
  logic out_hit;

  hit_scoreboard sb;
  int idle_cycles;
  bit timed_out;
  localparam int WATCHDOG_LIMIT = 2000;

  segment_collision_tests_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_seg_x(in_seg_x), .in_seg_y(in_seg_y),
    .in_seg_dx(in_seg_dx), .in_seg_dy(in_seg_dy),
    .in_other_x(in_other_x), .in_other_y(in_other_y),
    .in_other_u(in_other_u), .in_other_v(in_other_v),
    .in_radius(in_radius), .out_valid(out_valid), .out_hit(out_hit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Requests and results are both sampled here, before this edge's drives land.
  always @(posedge clk) begin
    query_t q;
    if (rst_n) begin
      if (start && !busy) begin
        q.opcode = sct_pkg::op_t'(in_opcode);
        q.seg_x = in_seg_x;
        q.seg_y = in_seg_y;
        q.seg_dx = in_seg_dx;
        q.seg_dy = in_seg_dy;
        q.other_x = in_other_x;
        q.other_y = in_other_y;
        q.other_u = in_other_u;
        q.other_v = in_other_v;
        q.radius = in_radius;
        sb.note_query(q);
      end
      if (out_valid) sb.check_hit(out_hit);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_query(query_t q, int gap);
    in_opcode <= q.opcode;
    in_seg_x <= q.seg_x;
    in_seg_y <= q.seg_y;
    in_seg_dx <= q.seg_dx;
    in_seg_dy <= q.seg_dy;
    in_other_x <= q.other_x;
    in_other_y <= q.other_y;
    in_other_u <= q.other_u;
    in_other_v <= q.other_v;
    in_radius <= q.radius;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic query_t make_query(sct_pkg::op_t op, int sx, int sy, int dx, int dy,
                                        int ox, int oy, int ou, int ov, int r);
    query_t q;
    q.opcode = op;
    q.seg_x = 16'(sx);
    q.seg_y = 16'(sy);
    q.seg_dx = 16'(dx);
    q.seg_dy = 16'(dy);
    q.other_x = 16'(ox);
    q.other_y = 16'(oy);
    q.other_u = 16'(ou);
    q.other_v = 16'(ov);
    q.radius = RB'(r);
    return q;
  endfunction

  function automatic int small_coord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic query_t random_query();
    query_t q;
    int span;
    q.opcode = sct_pkg::op_t'($urandom_range(0, 99) < 3 ? sct_pkg::OP_NONE
               : $urandom_range(sct_pkg::OP_SEG, sct_pkg::OP_CIRCLE));
    if ($urandom_range(0, 99) < 30) begin
      q.seg_x = 16'($urandom);
      q.seg_y = 16'($urandom);
      q.seg_dx = 16'($urandom);
      q.seg_dy = 16'($urandom);
      q.other_x = 16'($urandom);
      q.other_y = 16'($urandom);
      q.other_u = 16'($urandom);
      q.other_v = 16'($urandom);
      q.radius = RB'($urandom);
    end else begin
      // Clustered geometry so that hits and misses both come up often.
      span = $urandom_range(0, 3) == 0 ? 16000 : 64;
      q.seg_x = 16'(small_coord(span));
      q.seg_y = 16'(small_coord(span));
      q.seg_dx = 16'(small_coord(span));
      q.seg_dy = 16'(small_coord(span));
      q.other_x = 16'(small_coord(span));
      q.other_y = 16'(small_coord(span));
      q.other_u = 16'(small_coord(span));
      q.other_v = 16'(small_coord(span));
      q.radius = RB'($urandom_range(0, span));
    end
    return q;
  endfunction

  initial begin
    query_t directed[$];
    sb = new();
    idle_cycles = 0;
    timed_out = 1'b0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_opcode <= sct_pkg::OP_SEG;
    in_seg_x <= '0;
    in_seg_y <= '0;
    in_seg_dx <= '0;
    in_seg_dy <= '0;
    in_other_x <= '0;
    in_other_y <= '0;
    in_other_u <= '0;
    in_other_v <= '0;
    in_radius <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_query(sct_pkg::OP_SEG, 0, 0, 10, 10, 0, 10, 10, -10, 0));
    directed.push_back(make_query(sct_pkg::OP_SEG, 0, 0, 10, 0, 0, 5, 10, 0, 0));
    directed.push_back(make_query(sct_pkg::OP_SEG, 0, 0, 10, 0, 5, 0, 10, 0, 0));
    directed.push_back(make_query(sct_pkg::OP_SEG, 0, 0, 10, 0, 10, 0, 0, 7, 0));
    directed.push_back(make_query(sct_pkg::OP_SEG, 0, 0, 0, 0, 0, -5, 0, 10, 0));
    directed.push_back(make_query(sct_pkg::OP_SEG, -32768, -32768, 32767, 32767,
                                  32767, -32768, -32768, 32767, 32767));
    directed.push_back(make_query(sct_pkg::OP_SEG, 32767, 32767, -32768, -32768,
                                  -32768, 32767, 32767, -32768, 0));
    directed.push_back(make_query(sct_pkg::OP_BOX, -20, 0, 40, 0, -10, -10, 10, 10, 0));
    directed.push_back(make_query(sct_pkg::OP_BOX, -2, -2, 4, 4, -10, -10, 10, 10, 0));
    directed.push_back(make_query(sct_pkg::OP_BOX, -20, 0, 40, 0, 10, 10, -10, -10, 0));
    directed.push_back(make_query(sct_pkg::OP_BOX, 0, 0, 0, 0, -10, -10, 10, 10, 0));
    directed.push_back(make_query(sct_pkg::OP_BOX, -32768, -32768, -1, -1,
                                  -32768, -32768, 32767, 32767, 0));
    directed.push_back(make_query(sct_pkg::OP_CIRCLE, -10, 3, 20, 0, 0, 0, 0, 0, 5));
    directed.push_back(make_query(sct_pkg::OP_CIRCLE, -10, 5, 20, 0, 0, 0, 0, 0, 5));
    directed.push_back(make_query(sct_pkg::OP_CIRCLE, -10, 6, 20, 0, 0, 0, 0, 0, 5));
    directed.push_back(make_query(sct_pkg::OP_CIRCLE, 1, 1, 0, 0, 0, 0, -1, -1, 5));
    directed.push_back(make_query(sct_pkg::OP_CIRCLE, 3, 4, 0, 0, 0, 0, 0, 0, 5));
    directed.push_back(make_query(sct_pkg::OP_CIRCLE, -4, 0, 8, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_query(sct_pkg::OP_CIRCLE, -4, 1, 8, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_query(sct_pkg::OP_CIRCLE, 20, 0, 10, 0, 0, 0, 0, 0, 15));
    directed.push_back(make_query(sct_pkg::OP_CIRCLE, -32768, -32768, 32767, -1,
                                  32767, 32767, 0, 0, 32767));
    directed.push_back(make_query(sct_pkg::OP_NONE, 0, 0, 10, 10, 0, 10, 10, -10, 5));
    foreach (directed[i]) send_query(directed[i], i % 3 == 0 ? 1 : 0);

    for (int n = 0; n < 1450; n++) begin
      // Some stretches run back to back with no gaps at all.
      send_query(random_query(), (n / 100) % 4 == 1 ? 0 : pick_gap());
    end
    start <= 1'b0;

    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("covered %0d requests (seg %0d, box %0d, circle %0d, unused %0d), %0d hits",
             sb.queries, sb.per_op[sct_pkg::OP_SEG], sb.per_op[sct_pkg::OP_BOX],
             sb.per_op[sct_pkg::OP_CIRCLE], sb.per_op[sct_pkg::OP_NONE], sb.hits);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
